// File: src/assp_pkg.sv
// ============================================================================
// assp_pkg
// Shared types and constants for the Annex B SPS/PPS extractor.
// ============================================================================
package assp_pkg;

    // Unit size counter and the width of the size field on the result port.
    localparam int SIZE_BITS   = 16;
    localparam int UNIT_SIZE_W = 16;

    // Hold line that keeps back the tail of a unit.
    localparam int HOLD_DEPTH = 4;
    localparam int HOLD_IDX_W = $clog2(HOLD_DEPTH);
    localparam int HOLD_CNT_W = $clog2(HOLD_DEPTH + 1);

    // Queue between the classifier and the unit engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Byte values used by the start code and header scan.
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] START_BYTE = 8'h01;
    localparam logic [7:0] TYPE_MASK  = 8'h1f;
    localparam logic [4:0] TYPE_SPS   = 5'd7;
    localparam logic [4:0] TYPE_PPS   = 5'd8;

    // Operation codes passed from the classifier to the unit engine.
    typedef logic [1:0] t_op_code;
    localparam t_op_code OP_NONE   = 2'd0;
    localparam t_op_code OP_START  = 2'd1;
    localparam t_op_code OP_HEADER = 2'd2;
    localparam t_op_code OP_DATA   = 2'd3;

    // Input beat.
    typedef struct packed {
        logic [7:0] stream_byte;
        logic       end_of_stream;
    } t_in_beat;

    // Result beat.
    typedef struct packed {
        logic [7:0]             nal_byte;
        logic                   nal_kind;
        logic                   unit_last;
        logic [UNIT_SIZE_W-1:0] unit_size;
    } t_out_beat;

    // Classified byte as held in the queue.
    typedef struct packed {
        t_op_code   code;
        logic       kind;
        logic [7:0] data;
        logic       eos;
    } t_op;

endpackage

// File: src/assp_front.sv
// ============================================================================
// assp_front
// Classifier: scans the byte stream for start codes and headers and turns
// each accepted byte into an operation for the unit engine.
// ============================================================================
module assp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  assp_pkg::t_in_beat i_in,
    input  logic               i_full,
    output logic               o_push,
    output assp_pkg::t_op      o_op
);
    import assp_pkg::*;

    logic [1:0] r_zero_run;
    logic [1:0] n_zero_run;
    logic       r_expect;
    logic       n_expect;
    logic       accept;
    logic [4:0] nal_type;

    assign accept   = i_push && !i_full;
    assign nal_type = 5'(i_in.stream_byte & TYPE_MASK);

    // Classify the incoming byte and advance the scan state.
    always_comb begin
        n_zero_run = r_zero_run;
        n_expect   = r_expect;
        o_op.code  = OP_NONE;
        o_op.kind  = (nal_type == TYPE_PPS);
        o_op.data  = i_in.stream_byte;
        o_op.eos   = i_in.end_of_stream;
        if (i_in.stream_byte == START_BYTE && r_zero_run == 2'd3) begin
            o_op.code  = OP_START;
            n_expect   = 1'b1;
            n_zero_run = 2'd0;
        end else if (r_expect) begin
            n_expect   = 1'b0;
            n_zero_run = {1'b0, i_in.stream_byte == ZERO_BYTE};
            if (nal_type == TYPE_SPS || nal_type == TYPE_PPS) begin
                o_op.code = OP_HEADER;
            end
        end else begin
            if (i_in.stream_byte == ZERO_BYTE) begin
                n_zero_run = (r_zero_run == 2'd3) ? 2'd3 : r_zero_run + 2'd1;
            end else begin
                n_zero_run = 2'd0;
            end
            o_op.code = OP_DATA;
        end
        // End of stream restarts the scan.
        if (i_in.end_of_stream) begin
            n_zero_run = 2'd0;
            n_expect   = 1'b0;
        end
    end

    // Headers of other unit types leave the engine untouched and are not queued.
    assign o_push = accept && (o_op.code != OP_NONE);

    // Scan state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run <= 2'd0;
            r_expect   <= 1'b0;
        end else if (accept) begin
            r_zero_run <= n_zero_run;
            r_expect   <= n_expect;
        end
    end

endmodule

// File: src/assp_queue.sv
// ============================================================================
// assp_queue
// Short queue of classified bytes between the classifier and the unit engine.
// ============================================================================
module assp_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  assp_pkg::t_op i_op,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output assp_pkg::t_op o_op
);
    import assp_pkg::*;

    t_op                    r_entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_CNT_W-1:0] r_count;
    logic                   do_push;
    logic                   do_pop;

    assign o_full  = (r_count == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_entries[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entries[r_wr_ptr] <= i_op;
        end
    end

endmodule

// File: src/assp_back.sv
// ============================================================================
// assp_back
// Unit engine: keeps the hold line and the unit size count, and sends unit
// bytes to the output register one beat per cycle while that register is free.
// ============================================================================
module assp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_op_valid,
    input  assp_pkg::t_op       i_op,
    output logic                o_op_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output assp_pkg::t_out_beat o_out
);
    import assp_pkg::*;

    logic                  r_capturing;
    logic                  n_capturing;
    logic                  r_kind;
    logic                  n_kind;
    logic                  r_flush;
    logic                  n_flush;
    logic [7:0]            r_hold [HOLD_DEPTH];
    logic [7:0]            n_hold [HOLD_DEPTH];
    logic [HOLD_CNT_W-1:0] r_hold_cnt;
    logic [HOLD_CNT_W-1:0] n_hold_cnt;
    logic [SIZE_BITS-1:0]  r_byte_cnt;
    logic [SIZE_BITS-1:0]  n_byte_cnt;
    logic [SIZE_BITS-1:0]  byte_inc;
    t_out_beat             r_out;
    logic                  r_out_valid;
    logic                  out_free;
    logic                  hold_full;
    logic                  need_emit;
    logic                  emit;
    logic                  emit_last;

    assign out_free  = !r_out_valid || i_pop;
    assign hold_full = (r_hold_cnt == HOLD_CNT_W'(HOLD_DEPTH));
    assign byte_inc  = (r_byte_cnt == '1) ? r_byte_cnt : r_byte_cnt + 1'b1;
    assign need_emit = r_capturing && hold_full &&
                       (i_op.code == OP_START || i_op.code == OP_DATA);

    // Carry out one operation, or one flush beat at end of stream.
    always_comb begin
        n_capturing = r_capturing;
        n_kind      = r_kind;
        n_flush     = r_flush;
        n_hold      = r_hold;
        n_hold_cnt  = r_hold_cnt;
        n_byte_cnt  = r_byte_cnt;
        emit        = 1'b0;
        emit_last   = 1'b0;
        o_op_pop    = 1'b0;
        if (r_flush) begin
            // Drain the hold line, oldest byte first.
            if (out_free) begin
                emit       = 1'b1;
                emit_last  = (r_hold_cnt == HOLD_CNT_W'(1));
                n_byte_cnt = byte_inc;
                for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
                    n_hold[i] = r_hold[i+1];
                end
                n_hold_cnt = r_hold_cnt - 1'b1;
                if (emit_last) begin
                    n_flush     = 1'b0;
                    n_capturing = 1'b0;
                    n_hold_cnt  = '0;
                    n_byte_cnt  = '0;
                end
            end
        end else if (i_op_valid && (!need_emit || out_free)) begin
            o_op_pop = 1'b1;
            case (i_op.code)
                OP_START: begin
                    // The oldest held byte closes the unit; the rest are zeros
                    // of the start code.
                    if (need_emit) begin
                        emit       = 1'b1;
                        emit_last  = 1'b1;
                        n_byte_cnt = byte_inc;
                    end
                    n_capturing = 1'b0;
                    n_hold_cnt  = '0;
                end
                OP_HEADER: begin
                    n_capturing = 1'b1;
                    n_kind      = i_op.kind;
                    n_hold[0]   = i_op.data;
                    n_hold_cnt  = HOLD_CNT_W'(1);
                    n_byte_cnt  = '0;
                end
                OP_DATA: begin
                    if (r_capturing) begin
                        if (hold_full) begin
                            emit       = 1'b1;
                            n_byte_cnt = byte_inc;
                            for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
                                n_hold[i] = r_hold[i+1];
                            end
                            n_hold[HOLD_DEPTH-1] = i_op.data;
                        end else begin
                            n_hold[r_hold_cnt[HOLD_IDX_W-1:0]] = i_op.data;
                            n_hold_cnt = r_hold_cnt + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            // End of stream: flush a unit in progress, otherwise restart.
            if (i_op.eos) begin
                if (n_capturing) begin
                    n_flush = 1'b1;
                end else begin
                    n_hold_cnt = '0;
                    n_byte_cnt = '0;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capturing <= 1'b0;
            r_kind      <= 1'b0;
            r_flush     <= 1'b0;
            r_hold_cnt  <= '0;
            r_byte_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_capturing <= n_capturing;
            r_kind      <= n_kind;
            r_flush     <= n_flush;
            r_hold_cnt  <= n_hold_cnt;
            r_byte_cnt  <= n_byte_cnt;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold line and output register payload.
    always_ff @(posedge i_clk) begin
        r_hold <= n_hold;
        if (emit) begin
            r_out.nal_byte  <= r_hold[0];
            r_out.nal_kind  <= r_kind;
            r_out.unit_last <= emit_last;
            r_out.unit_size <= emit_last ? UNIT_SIZE_W'(byte_inc) : '0;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_out   = r_out;

endmodule

// File: src/annexb_sps_pps_extractor.sv
// ============================================================================
// annexb_sps_pps_extractor
// Pulls SPS and PPS units out of an H.264 Annex B byte stream.
// ============================================================================
// The block takes one stream byte per cycle and passes on the bytes of every
// SPS and PPS unit, header first, each beat tagged with the unit kind; the
// final byte of a unit carries the last flag and the saturating unit size.
// Only the four-byte start code is recognized. A classifier finds start codes
// and headers and feeds a four-entry queue; the unit engine behind it keeps a
// four-byte hold line and writes one result beat per cycle, while results
// are taken, into an output register. Sustained throughput is one byte per
// cycle. A byte that ends the stream inside a unit makes the engine drain
// the hold line before it takes more bytes. At full input rate the queue
// holds one byte, so its three spare entries keep taking input bytes during
// the drain until the queue fills and the input stalls; it stalls longer when
// end-of-stream bytes arrive close together or results are not taken. From
// input to result a byte passes the queue, the hold line and the output register.
module annexb_sps_pps_extractor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  assp_pkg::t_in_beat  i_in,
    input  logic                i_push,
    output logic                o_full,
    output assp_pkg::t_out_beat o_out,
    output logic                o_empty,
    input  logic                i_pop
);
    import assp_pkg::*;

    logic q_push;
    t_op  q_in;
    logic q_valid;
    t_op  q_out;
    logic q_pop;

    // Start code and header classification.
    assp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_in    (i_in),
        .i_full  (o_full),
        .o_push  (q_push),
        .o_op    (q_in)
    );

    // Decoupling queue.
    assp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in),
        .i_pop   (q_pop),
        .o_full  (o_full),
        .o_valid (q_valid),
        .o_op    (q_out)
    );

    // Hold line, size count and output register.
    assp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .i_op       (q_out),
        .o_op_pop   (q_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_out      (o_out)
    );

endmodule

// File: src/assp_checker.sv
// ============================================================================
// assp_checker
// Port-level checks for the Annex B SPS/PPS extractor.
// ============================================================================
module assp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input assp_pkg::t_in_beat  i_in,
    input logic                i_push,
    input logic                o_full,
    input assp_pkg::t_out_beat o_out,
    input logic                o_empty,
    input logic                i_pop
);
    import assp_pkg::*;

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result waiting after reset");

    // A waiting result holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_out))
        else $error("waiting result changed before it was taken");

    // Only the final beat of a unit carries a size.
    a_size_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !o_out.unit_last |-> o_out.unit_size == '0)
        else $error("size shown on a beat that is not last");

    // A finished unit holds at least its header byte.
    a_size_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_out.unit_last |-> o_out.unit_size != '0)
        else $error("last beat with zero unit size");

endmodule

bind annexb_sps_pps_extractor assp_checker u_assp_checker (.*);
